FILE: src/portable_path_validator_macros.svh
// ---------------------------------------------------------------------------
// portable_path_validator_macros.svh
// assertion shorthands used by portable_path_validator
// ---------------------------------------------------------------------------
`ifndef PORTABLE_PATH_VALIDATOR_MACROS_SVH
`define PORTABLE_PATH_VALIDATOR_MACROS_SVH

// expression must hold at every clock edge out of reset
`define PPV_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ppv_pkg.sv
// ---------------------------------------------------------------------------
// ppv_pkg
// Shared types, constants and byte/segment checks of the path validator.
// ---------------------------------------------------------------------------
package ppv_pkg;

	localparam int PATH_W  = 13;
	localparam int SEG_W   = 9;
	localparam int LIMIT_W = 8;
	localparam int STEM_W  = 3;

	localparam logic [PATH_W-1:0]  PATH_CNT_MAX   = 13'd8191;
	localparam logic [SEG_W-1:0]   SEG_CNT_MAX    = 9'd511;
	localparam logic [STEM_W-1:0]  STEM_CNT_MAX   = 3'd5;
	localparam logic [PATH_W-1:0]  PATH_LIMIT_RST = 13'd1024;
	localparam logic [LIMIT_W-1:0] SEG_LIMIT_RST  = 8'd255;

	// configuration register indexes
	localparam logic [0:0] CFG_MAX_PATH = 1'b0;
	localparam logic [0:0] CFG_MAX_SEG  = 1'b1;

	localparam logic [7:0] CHR_LOW    = 8'h20;
	localparam logic [7:0] CHR_HIGH   = 8'h7e;
	localparam logic [7:0] CHR_SLASH  = 8'h2f;
	localparam logic [7:0] CHR_DOT    = 8'h2e;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_BSLASH = 8'h5c;
	localparam logic [7:0] CHR_COLON  = 8'h3a;
	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_LT     = 8'h3c;
	localparam logic [7:0] CHR_GT     = 8'h3e;
	localparam logic [7:0] CHR_PIPE   = 8'h7c;
	localparam logic [7:0] CHR_QMARK  = 8'h3f;
	localparam logic [7:0] CHR_STAR   = 8'h2a;
	localparam logic [7:0] CHR_UP_A   = 8'h41;
	localparam logic [7:0] CHR_UP_Z   = 8'h5a;
	localparam logic [7:0] CHR_ONE    = 8'h31;
	localparam logic [7:0] CHR_NINE   = 8'h39;

	localparam logic [23:0] WORD_CON = "con";
	localparam logic [23:0] WORD_PRN = "prn";
	localparam logic [23:0] WORD_AUX = "aux";
	localparam logic [23:0] WORD_NUL = "nul";
	localparam logic [23:0] WORD_COM = "com";
	localparam logic [23:0] WORD_LPT = "lpt";

	typedef logic [3:0][7:0] stem_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last;
		logic       empty_path;
	} item_t;

	typedef struct packed {
		logic [PATH_W-1:0]  max_path;
		logic [LIMIT_W-1:0] max_seg;
	} cfg_t;

	typedef struct packed {
		logic has_result;
		logic ok;
	} verdict_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_forbidden(input logic [7:0] c);
		logic bad;
		case (c) inside
			[8'h00:8'h1f], [8'h7f:8'hff],
			CHR_BSLASH, CHR_COLON, CHR_QUOTE, CHR_LT,
			CHR_GT, CHR_PIPE, CHR_QMARK, CHR_STAR: bad = 1'b1;
			default: bad = 1'b0;
		endcase
		return bad;
	endfunction

	// device names such as con, nul, com1..com9
	function automatic logic stem_reserved(input stem_t s, input logic [STEM_W-1:0] cnt);
		logic [23:0] w;
		logic        hit;
		w   = {to_lower(s[0]), to_lower(s[1]), to_lower(s[2])};
		hit = 1'b0;
		if (cnt == 3'd3) begin
			hit = (w == WORD_CON) || (w == WORD_PRN) || (w == WORD_AUX) || (w == WORD_NUL);
		end else if (cnt == 3'd4 && s[3] >= CHR_ONE && s[3] <= CHR_NINE) begin
			hit = (w == WORD_COM) || (w == WORD_LPT);
		end
		return hit;
	endfunction

	function automatic logic segment_bad(
		input logic [SEG_W-1:0]   seg_cnt,
		input logic               all_dots,
		input logic [LIMIT_W-1:0] max_seg,
		input logic [7:0]         prev,
		input logic [STEM_W-1:0]  stem_cnt,
		input stem_t              stem
	);
		return (seg_cnt == '0) || all_dots || (seg_cnt > {1'b0, max_seg}) ||
			(prev == CHR_DOT) || (prev == CHR_SPACE) || stem_reserved(stem, stem_cnt);
	endfunction

endpackage

FILE: src/portable_path_validator.sv
// ---------------------------------------------------------------------------
// portable_path_validator
// Checks a relative path, one byte per request, for portable file naming.
// ---------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   char_byte, last, empty_path
//  out       source     out_valid / out_ready path_ok
//  cfg       sink       cfg_we                cfg_index, cfg_wdata
//
//  one request per cycle while in_ready is high; a byte goes through an
//  input stage and the verdict register, so a verdict is offered once its
//  last byte leaves the input stage; the path state registers set the rate.
//  arst_n clears the path state and loads the limit reset values.
//  a held verdict stalls a staged request that ends a path, and the input.
// ---------------------------------------------------------------------------
`include "portable_path_validator_macros.svh"

module portable_path_validator import ppv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_byte,
	input  logic              last,
	input  logic              empty_path,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              path_ok,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [PATH_W-1:0] cfg_wdata
);

	logic     v_s1;
	item_t    item_s1;
	logic     out_valid_q;
	logic     path_ok_q;
	cfg_t     cfg;
	verdict_t verdict;
	logic     s1_go;

	ppv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ppv_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (s1_go),
		.item    (item_s1),
		.cfg     (cfg),
		.verdict (verdict)
	);

	// a staged byte moves on unless its verdict would hit a full output
	assign s1_go    = v_s1 & (!verdict.has_result | !out_valid_q | out_ready);
	assign in_ready = !v_s1 | s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.char_byte  <= char_byte;
			item_s1.last       <= last;
			item_s1.empty_path <= empty_path;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && verdict.has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && verdict.has_result) begin
			path_ok_q <= verdict.ok;
		end
	end

	assign out_valid = out_valid_q;
	assign path_ok   = path_ok_q;

	`PPV_ASSERT_ALWAYS(a_no_verdict_overwrite, clk, arst_n, !(s1_go && verdict.has_result && out_valid_q && !out_ready), "verdict overwrote a pending result")
	`PPV_ASSERT_ALWAYS(a_ready_when_stage_empty, clk, arst_n, v_s1 || in_ready, "input stalled with an empty stage")
	`PPV_ASSERT_NEXT(a_stalled_stage_holds, clk, arst_n, v_s1 && !s1_go, v_s1 && $stable(item_s1), "stalled request lost or changed")

endmodule

FILE: src/ppv_cfg_regs.sv
// ---------------------------------------------------------------------------
// ppv_cfg_regs
// Limit registers written through the configuration port.
// ---------------------------------------------------------------------------
module ppv_cfg_regs import ppv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [PATH_W-1:0] cfg_wdata,
	output cfg_t              cfg
);

	logic [PATH_W-1:0]  max_path_q;
	logic [LIMIT_W-1:0] max_seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_q <= PATH_LIMIT_RST;
			max_seg_q  <= SEG_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_PATH: max_path_q <= cfg_wdata;
				CFG_MAX_SEG:  max_seg_q  <= cfg_wdata[LIMIT_W-1:0];
			endcase
		end
	end

	assign cfg.max_path = max_path_q;
	assign cfg.max_seg  = max_seg_q;

endmodule

FILE: src/ppv_scan.sv
// ---------------------------------------------------------------------------
// ppv_scan
// Per-byte path state and the verdict logic for the staged request.
// ---------------------------------------------------------------------------
module ppv_scan import ppv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  item_t    item,
	input  cfg_t     cfg,
	output verdict_t verdict
);

	logic               reject_q;
	logic [PATH_W-1:0]  path_cnt_q;
	logic [SEG_W-1:0]   seg_cnt_q;
	logic               all_dots_q;
	logic               stem_closed_q;
	stem_t              stem_q;
	logic [STEM_W-1:0]  stem_cnt_q;
	logic [7:0]         prev_q;

	logic [7:0]         c;
	logic               is_slash;
	logic               is_dot;
	logic [PATH_W-1:0]  path_n;
	logic [SEG_W-1:0]   seg_n;
	logic               dots_n;
	logic               closed_n;
	stem_t              stem_n;
	logic [STEM_W-1:0]  stem_cnt_n;
	logic               close_fail;
	logic               reject_n;
	logic               end_fail;

	always_comb begin
		c          = item.char_byte;
		is_slash   = (c == CHR_SLASH);
		is_dot     = (c == CHR_DOT);
		path_n     = (path_cnt_q == PATH_CNT_MAX) ? path_cnt_q : path_cnt_q + 13'd1;
		seg_n      = seg_cnt_q;
		dots_n     = all_dots_q;
		closed_n   = stem_closed_q;
		stem_n     = stem_q;
		stem_cnt_n = stem_cnt_q;
		close_fail = 1'b0;
		if (is_slash) begin
			// segment ends before this byte
			close_fail = segment_bad(seg_cnt_q, all_dots_q, cfg.max_seg, prev_q,
				stem_cnt_q, stem_q);
			seg_n      = '0;
			dots_n     = 1'b1;
			closed_n   = 1'b0;
			stem_cnt_n = '0;
		end else begin
			if (seg_cnt_q != SEG_CNT_MAX) begin
				seg_n = seg_cnt_q + 9'd1;
			end
			if (!is_dot) begin
				dots_n = 1'b0;
			end
			if (!stem_closed_q) begin
				if (is_dot) begin
					closed_n = 1'b1;
				end else begin
					// only the first four stem bytes are kept
					if (!stem_cnt_q[2]) begin
						stem_n[stem_cnt_q[1:0]] = c;
					end
					if (stem_cnt_q != STEM_CNT_MAX) begin
						stem_cnt_n = stem_cnt_q + 3'd1;
					end
				end
			end
		end
		reject_n = reject_q | is_forbidden(c) | close_fail;
		// final segment plus total length, seen only on the last byte
		end_fail = segment_bad(seg_n, dots_n, cfg.max_seg, c, stem_cnt_n, stem_n) |
			(path_n > cfg.max_path);
		verdict.has_result = item.last | item.empty_path;
		verdict.ok         = !item.empty_path & !reject_n & !end_fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q      <= 1'b0;
			path_cnt_q    <= '0;
			seg_cnt_q     <= '0;
			all_dots_q    <= 1'b1;
			stem_closed_q <= 1'b0;
			stem_cnt_q    <= '0;
			prev_q        <= '0;
		end else if (go) begin
			if (verdict.has_result) begin
				reject_q      <= 1'b0;
				path_cnt_q    <= '0;
				seg_cnt_q     <= '0;
				all_dots_q    <= 1'b1;
				stem_closed_q <= 1'b0;
				stem_cnt_q    <= '0;
				prev_q        <= '0;
			end else begin
				reject_q      <= reject_n;
				path_cnt_q    <= path_n;
				seg_cnt_q     <= seg_n;
				all_dots_q    <= dots_n;
				stem_closed_q <= closed_n;
				stem_cnt_q    <= stem_cnt_n;
				prev_q        <= c;
			end
		end
	end

	// stem bytes are read only below the stem count
	always_ff @(posedge clk) begin
		if (go) begin
			stem_q <= stem_n;
		end
	end

endmodule

FILE: tb/sv/path_verdict_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// path_verdict_checker
// Watches the byte and verdict channels of the path validator, keeps its own
// copy of the path state and limits, and compares every verdict in order.
// ---------------------------------------------------------------------------
module path_verdict_checker import ppv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        char_byte,
	input  logic              last,
	input  logic              empty_path,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              path_ok,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [PATH_W-1:0] cfg_wdata,
	output int                mismatches,
	output int                pending,
	output int                paths_accepted,
	output int                paths_rejected
);

	// limits as the block should hold them
	logic [PATH_W-1:0]  lim_path;
	logic [LIMIT_W-1:0] lim_seg;

	// running state of the path being received
	logic               rejected;
	logic [PATH_W-1:0]  path_len;
	logic [SEG_W-1:0]   seg_len;
	logic               seg_dots;
	logic               stem_done;
	logic [7:0]         stem [0:3];
	logic [STEM_W-1:0]  stem_len;
	logic [7:0]         prev_char;

	logic               expected_verdicts [$];
	logic               has_verdict;
	logic               verdict;
	logic               oldest;

	int fail_count     = 0;
	int waiting        = 0;
	int accepted_count = 0;
	int rejected_count = 0;

	assign mismatches     = fail_count;
	assign pending        = waiting;
	assign paths_accepted = accepted_count;
	assign paths_rejected = rejected_count;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	function automatic logic is_device_name();
		logic [23:0] word;
		word = {fold_case(stem[0]), fold_case(stem[1]), fold_case(stem[2])};
		if (stem_len == 3'd3) begin
			return word == WORD_CON || word == WORD_PRN || word == WORD_AUX ||
				word == WORD_NUL;
		end
		if (stem_len == 3'd4 && stem[3] >= CHR_ONE && stem[3] <= CHR_NINE) begin
			return word == WORD_COM || word == WORD_LPT;
		end
		return 1'b0;
	endfunction

	function automatic logic is_bad_char(input logic [7:0] c);
		return c < CHR_LOW || c > CHR_HIGH || c == CHR_BSLASH || c == CHR_COLON ||
			c == CHR_QUOTE || c == CHR_LT || c == CHR_GT || c == CHR_PIPE ||
			c == CHR_QMARK || c == CHR_STAR;
	endfunction

	task automatic clear_segment();
		seg_len   = '0;
		seg_dots  = 1'b1;
		stem_done = 1'b0;
		for (int i = 0; i < 4; i++) begin
			stem[i] = '0;
		end
		stem_len  = '0;
	endtask

	task automatic clear_path();
		rejected  = 1'b0;
		path_len  = '0;
		prev_char = '0;
		clear_segment();
	endtask

	task automatic close_segment();
		if (seg_len == '0 || seg_dots || seg_len > {1'b0, lim_seg} ||
				prev_char == CHR_DOT || prev_char == CHR_SPACE || is_device_name()) begin
			rejected = 1'b1;
		end
	endtask

	task automatic predict_verdict(
		input  logic [7:0] c,
		input  logic       is_last,
		input  logic       is_empty,
		output logic       has,
		output logic       ok
	);
		has = 1'b0;
		ok  = 1'b0;
		if (is_empty) begin
			// partial path is dropped, last is ignored
			clear_path();
			has = 1'b1;
		end else begin
			if (path_len < PATH_CNT_MAX) begin
				path_len++;
			end
			if (is_bad_char(c)) begin
				rejected = 1'b1;
			end
			if (c == CHR_SLASH) begin
				close_segment();
				clear_segment();
			end else begin
				if (seg_len < SEG_CNT_MAX) begin
					seg_len++;
				end
				if (c != CHR_DOT) begin
					seg_dots = 1'b0;
				end
				if (!stem_done) begin
					if (c == CHR_DOT) begin
						stem_done = 1'b1;
					end else begin
						if (stem_len < 3'd4) begin
							stem[stem_len[1:0]] = c;
						end
						if (stem_len < STEM_CNT_MAX) begin
							stem_len++;
						end
					end
				end
			end
			prev_char = c;
			if (is_last) begin
				// trailing slash leaves an empty final segment
				close_segment();
				if (path_len > lim_path) begin
					rejected = 1'b1;
				end
				has = 1'b1;
				ok  = !rejected;
				clear_path();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_path = PATH_LIMIT_RST;
			lim_seg  = SEG_LIMIT_RST;
			clear_path();
			expected_verdicts.delete();
			waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("verdict %0b with no path pending", path_ok));
				end else begin
					oldest = expected_verdicts.pop_front();
					if (path_ok !== oldest) begin
						report_mismatch($sformatf("path_ok %0b, expected %0b", path_ok, oldest));
					end
					if (oldest) begin
						accepted_count++;
					end else begin
						rejected_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_verdict(char_byte, last, empty_path, has_verdict, verdict);
				if (has_verdict) begin
					expected_verdicts.insert(expected_verdicts.size(), verdict);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_PATH: lim_path = cfg_wdata;
					CFG_MAX_SEG:  lim_seg  = cfg_wdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			waiting = expected_verdicts.size();
		end
	end

endmodule

FILE: tb/sv/portable_path_validator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// portable_path_validator_test
// Drives paths byte by byte into the validator under several limit settings,
// with random idling on both channels and a long receiver hold-off; a
// checker beside the block predicts and compares every verdict.
// ---------------------------------------------------------------------------
module portable_path_validator_test import ppv_pkg::*;;

	localparam int     HALF_PERIOD   = 6;
	localparam int     RESET_CYCLES  = 12;
	localparam int     SETTLE_CYCLES = 4;
	localparam int     HOLD_CYCLES   = 200;
	localparam longint TIMEOUT_NS    = 10_000_000;
	localparam logic [7:0] LOWER_A   = 8'h61;
	localparam logic [7:0] UPPER_A   = 8'h41;
	localparam logic [7:0] DIGIT_0   = 8'h30;
	localparam logic [7:0] DASH      = 8'h2d;
	localparam logic [7:0] UNDERLINE = 8'h5f;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	wire               in_ready;
	logic [7:0]        char_byte  = '0;
	logic              last       = 1'b0;
	logic              empty_path = 1'b0;
	wire               out_valid;
	logic              out_ready  = 1'b0;
	wire               path_ok;
	logic              cfg_we     = 1'b0;
	logic [0:0]        cfg_index  = CFG_MAX_PATH;
	logic [PATH_W-1:0] cfg_wdata  = '0;

	int mismatches;
	int pending;
	int paths_accepted;
	int paths_rejected;

	logic [7:0]        path_bytes [$];
	int                sent_total   = 0;
	int                settings     = 1;
	int                hold_asks    = 0;
	bit                idle_on      = 1'b1;
	int                cur_path_lim = int'(PATH_LIMIT_RST);
	int                cur_seg_lim  = int'(SEG_LIMIT_RST);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	portable_path_validator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_byte  (char_byte),
		.last       (last),
		.empty_path (empty_path),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.path_ok    (path_ok),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	path_verdict_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_byte      (char_byte),
		.last           (last),
		.empty_path     (empty_path),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.path_ok        (path_ok),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.pending        (pending),
		.paths_accepted (paths_accepted),
		.paths_rejected (paths_rejected)
	);

	// verdict receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_served;
		int n;
		hold_served = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				out_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic offer_byte(input logic [7:0] c, input logic is_last, input logic is_empty);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		char_byte  <= c;
		last       <= is_last;
		empty_path <= is_empty;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_total++;
	endtask

	task automatic offer_text(input string s, input logic with_last);
		for (int i = 0; i < s.len(); i++) begin
			offer_byte(s[i], with_last && i == s.len() - 1, 1'b0);
		end
	endtask

	// a zero-length path can only go as an empty_path request
	task automatic offer_path();
		int n;
		n = path_bytes.size();
		if (n == 0) begin
			offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			for (int i = 0; i < n; i++) begin
				offer_byte(path_bytes[i], i == n - 1, 1'b0);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_limits(input int path_lim, input int seg_lim);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_PATH;
		cfg_wdata <= path_lim[PATH_W-1:0];
		@(posedge clk);
		// upper bits beyond the segment register are don't-care
		cfg_index <= CFG_MAX_SEG;
		cfg_wdata <= {5'($urandom_range(0, 31)), seg_lim[LIMIT_W-1:0]};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_path_lim = path_lim;
		cur_seg_lim  = seg_lim;
		settings++;
	endtask

	task automatic append_byte(input logic [7:0] c);
		path_bytes.insert(path_bytes.size(), c);
	endtask

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8) begin
			return LOWER_A + 8'($urandom_range(0, 25));
		end else if (r < 12) begin
			return UPPER_A + 8'($urandom_range(0, 25));
		end else if (r < 16) begin
			return DIGIT_0 + 8'($urandom_range(0, 9));
		end else if (r == 16) begin
			return DASH;
		end else if (r == 17) begin
			return UNDERLINE;
		end else if (r == 18) begin
			return $urandom_range(0, 1) ? CHR_DOT : CHR_SPACE;
		end
		return 8'($urandom_range(CHR_LOW, CHR_HIGH));
	endfunction

	function automatic logic [7:0] banned_char();
		case ($urandom_range(0, 7))
			0: return CHR_BSLASH;
			1: return CHR_COLON;
			2: return CHR_QUOTE;
			3: return CHR_LT;
			4: return CHR_GT;
			5: return CHR_PIPE;
			6: return CHR_QMARK;
			default: return CHR_STAR;
		endcase
	endfunction

	task automatic add_name(input int n);
		for (int i = 0; i < n; i++) begin
			append_byte(name_char());
		end
	endtask

	task automatic add_letters(input int n);
		for (int i = 0; i < n; i++) begin
			append_byte(LOWER_A + 8'($urandom_range(0, 25)));
		end
	endtask

	// device names in random case, with or without a digit and extension
	task automatic add_device_name();
		string      words;
		int         w;
		logic [7:0] c;
		words = "conprnauxnulcomlpt";
		w = $urandom_range(0, 5);
		for (int k = 0; k < 3; k++) begin
			c = words[w * 3 + k];
			if ($urandom_range(0, 1)) begin
				c = c - 8'd32;
			end
			append_byte(c);
		end
		if ((w >= 4) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0)) begin
			append_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 2) == 0) begin
			append_byte(CHR_DOT);
			add_name($urandom_range(1, 3));
		end
	endtask

	task automatic add_segment();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			add_name($urandom_range(1, 10));
			if ($urandom_range(0, 3) == 0) begin
				append_byte(CHR_DOT);
				add_name($urandom_range(1, 4));
			end
		end else if (kind < 62) begin
			add_device_name();
		end else if (kind < 67) begin
			append_byte(CHR_DOT);
			if ($urandom_range(0, 1)) begin
				append_byte(CHR_DOT);
			end
		end else if (kind < 70) begin
			// empty segment
		end else if (kind < 76) begin
			add_name($urandom_range(1, 6));
			append_byte($urandom_range(0, 1) ? CHR_DOT : CHR_SPACE);
		end else if (kind < 84) begin
			add_name($urandom_range(1, 4));
			append_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : banned_char());
			add_name($urandom_range(0, 3));
		end else if (kind < 90) begin
			n = cur_seg_lim + int'($urandom_range(0, 2)) - 1;
			add_letters(n < 1 ? 1 : n);
		end else begin
			repeat ($urandom_range(0, 3)) append_byte(CHR_DOT);
			add_name($urandom_range(1, 4));
			if ($urandom_range(0, 1)) begin
				append_byte(CHR_DOT);
				add_name($urandom_range(1, 3));
			end
		end
	endtask

	task automatic build_path();
		int nseg;
		path_bytes.delete();
		if ($urandom_range(0, 19) == 0) begin
			append_byte(CHR_SLASH);
		end
		nseg = $urandom_range(1, 4);
		for (int k = 0; k < nseg; k++) begin
			if (k > 0) begin
				append_byte(CHR_SLASH);
			end
			add_segment();
		end
		if ($urandom_range(0, 19) == 0) begin
			append_byte(CHR_SLASH);
		end
	endtask

	// path of exactly n bytes: eight-letter segments, the last of one to nine letters
	task automatic build_long_path(input int n);
		path_bytes.delete();
		for (int i = 0; i < n; i++) begin
			if (i % 9 == 8 && i != n - 1) begin
				append_byte(CHR_SLASH);
			end else begin
				append_byte(LOWER_A + 8'($urandom_range(0, 25)));
			end
		end
	endtask

	task automatic run_random_paths(input int budget);
		int phase_end;
		int r;
		int n;
		phase_end = sent_total + budget;
		while (sent_total < phase_end) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				build_path();
				offer_path();
			end else if (r < 92) begin
				// broken path: a prefix, then an empty_path request drops it
				build_path();
				n = path_bytes.size();
				for (int i = 0; i < n - 1; i++) begin
					offer_byte(path_bytes[i], 1'b0, 1'b0);
				end
				offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end else if (r < 97) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					offer_byte(8'($urandom_range(0, 255)), i == n - 1, 1'b0);
				end
			end else begin
				offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end
		end
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d verdicts outstanding", pending);
		$display("** portable_path_validator: FAILED **");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed paths under the reset limits
		offer_text("a", 1'b1);
		offer_byte(8'h00, 1'b1, 1'b0);
		offer_byte(8'hff, 1'b1, 1'b0);
		offer_byte(CHR_HIGH, 1'b1, 1'b0);
		offer_byte(CHR_SPACE, 1'b1, 1'b0);
		offer_text("ab", 1'b0);
		offer_byte(8'hff, 1'b1, 1'b1);
		offer_byte(8'h00, 1'b0, 1'b1);
		offer_text("/a", 1'b1);
		offer_text("a/", 1'b1);
		offer_text("CoN", 1'b1);
		offer_text("lpt9.x", 1'b1);
		offer_text(".", 1'b1);
		run_random_paths(300);

		// small limits: path and segment right at and past the edge
		apply_limits(48, 8);
		build_long_path(cur_path_lim);
		offer_path();
		build_long_path(cur_path_lim + 1);
		offer_path();
		path_bytes.delete();
		add_letters(cur_seg_lim);
		offer_path();
		path_bytes.delete();
		add_letters(cur_seg_lim + 1);
		offer_path();

		// top path limit
		apply_limits(int'(PATH_CNT_MAX), int'(SEG_LIMIT_RST));
		run_random_paths(150);

		apply_limits(4096, int'(SEG_LIMIT_RST));
		run_random_paths(200);

		// zero limits reject every non-empty path
		apply_limits(0, 0);
		run_random_paths(80);

		apply_limits(1, 1);
		run_random_paths(150);

		apply_limits($urandom_range(2, 40), $urandom_range(2, 12));
		hold_asks++;
		run_random_paths(300);

		apply_limits(12, 4);
		idle_on = 1'b0;
		run_random_paths(350);

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d requests and %0d paths (%0d accepted, %0d rejected)",
			sent_total, paths_accepted + paths_rejected, paths_accepted, paths_rejected);
		$display("over %0d limit settings incl. zero and saturated limits and a %0d-cycle hold-off",
			settings, HOLD_CYCLES);
		if (mismatches == 0 && pending == 0) begin
			$display("** portable_path_validator: PASSED **");
		end else begin
			$display("** portable_path_validator: FAILED **");
		end
		$finish;
	end

endmodule
